/* hdl/bqd_pkg.sv */
// Shared constants, codes and types for the biquad direct form II filter.
package bqd_pkg;

  localparam int CHANNELS    = 2;
  localparam int CHAN_BITS   = 1;
  localparam int IDX_BITS    = 1;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int DELAY_BITS  = 32;
  localparam int COEF_FRAC   = COEF_BITS - 2;
  localparam int DELAY_FRAC  = 24;
  localparam int ACC_FRAC    = DELAY_FRAC + COEF_FRAC;
  localparam int X_ALIGN     = ACC_FRAC - (SAMPLE_BITS - 1);
  localparam int Y_DROP      = ACC_FRAC - (SAMPLE_BITS - 1);
  localparam int PROD_BITS   = COEF_BITS + DELAY_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int CFG_IDX_BITS = 3;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

  typedef enum logic [2:0] {
    CSEL_B0,
    CSEL_B1,
    CSEL_B2,
    CSEL_A1,
    CSEL_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    DSEL_W1,
    DSEL_W2,
    DSEL_W
  } data_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB_P,
    ACC_ADD_P,
    ACC_LOAD_P
  } acc_op_t;

  typedef struct packed {
    logic      capture;
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      w_load;
    logic      out_load;
    logic      state_wr;
  } cmd_t;

endpackage

/* hdl/bqd_ctrl.sv */
// Sequencer for the shared multiply-accumulate schedule and the output handshake.
module bqd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output bqd_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MA1  = 3'd1;
  localparam logic [2:0] ST_MA2  = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_MB0  = 3'd5;
  localparam logic [2:0] ST_MB   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.coef_sel = bqd_pkg::CSEL_A1;
    cmd.data_sel = bqd_pkg::DSEL_W1;
    cmd.acc_op   = bqd_pkg::ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MA1;
        end
      end
      ST_MA1: begin
        cmd.coef_sel = bqd_pkg::CSEL_A1;
        cmd.data_sel = bqd_pkg::DSEL_W1;
        cmd.acc_op   = bqd_pkg::ACC_LOAD_X;
        state_next   = ST_MA2;
      end
      ST_MA2: begin
        cmd.coef_sel = bqd_pkg::CSEL_A2;
        cmd.data_sel = bqd_pkg::DSEL_W2;
        cmd.acc_op   = bqd_pkg::ACC_SUB_P;
        state_next   = ST_SUB;
      end
      ST_SUB: begin
        cmd.coef_sel = bqd_pkg::CSEL_B1;
        cmd.data_sel = bqd_pkg::DSEL_W1;
        cmd.acc_op   = bqd_pkg::ACC_SUB_P;
        state_next   = ST_WR;
      end
      ST_WR: begin
        cmd.coef_sel = bqd_pkg::CSEL_B2;
        cmd.data_sel = bqd_pkg::DSEL_W2;
        cmd.acc_op   = bqd_pkg::ACC_LOAD_P;
        cmd.w_load   = 1'b1;
        state_next   = ST_MB0;
      end
      ST_MB0: begin
        cmd.coef_sel = bqd_pkg::CSEL_B0;
        cmd.data_sel = bqd_pkg::DSEL_W;
        cmd.acc_op   = bqd_pkg::ACC_ADD_P;
        state_next   = ST_MB;
      end
      ST_MB: begin
        cmd.acc_op = bqd_pkg::ACC_ADD_P;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.state_wr = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/bqd_datapath.sv */
// Coefficient registers, delay store, shared multiplier, accumulator and output register.
module bqd_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  bqd_pkg::cmd_t                           cmd,
  input  logic                                    cfg_we,
  input  logic [bqd_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [bqd_pkg::COEF_BITS-1:0]           cfg_data,
  input  logic [bqd_pkg::CHAN_BITS-1:0]           chan_in,
  input  logic signed [bqd_pkg::SAMPLE_BITS-1:0]  sample_in,
  output logic [bqd_pkg::CHAN_BITS-1:0]           chan_out,
  output logic signed [bqd_pkg::SAMPLE_BITS-1:0]  sample_out
);

  localparam int ACC_BITS   = bqd_pkg::ACC_BITS;
  localparam int DELAY_BITS = bqd_pkg::DELAY_BITS;
  localparam int SMP_BITS   = bqd_pkg::SAMPLE_BITS;

  localparam logic signed [ACC_BITS-1:0] W_HALF =
    ACC_BITS'(64'sd1 <<< (bqd_pkg::COEF_FRAC - 1));
  localparam logic signed [ACC_BITS-1:0] Y_HALF =
    ACC_BITS'(64'sd1 <<< (bqd_pkg::Y_DROP - 1));
  localparam logic signed [ACC_BITS-1:0] W_MAX = ACC_BITS'((64'sd1 <<< (DELAY_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] W_MIN = -W_MAX - 1;
  localparam logic signed [ACC_BITS-1:0] Y_MAX = ACC_BITS'((64'sd1 <<< (SMP_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - 1;

  logic signed [bqd_pkg::COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [DELAY_BITS-1:0] delay_one [bqd_pkg::CHANNELS];
  logic signed [DELAY_BITS-1:0] delay_two [bqd_pkg::CHANNELS];

  logic [bqd_pkg::IDX_BITS-1:0]   idx_in;
  logic [bqd_pkg::CHAN_BITS-1:0]  chan;
  logic [bqd_pkg::IDX_BITS-1:0]   idx;
  logic signed [SMP_BITS-1:0]     x;
  logic signed [DELAY_BITS-1:0]   w1, w2, w;
  logic signed [bqd_pkg::COEF_BITS-1:0] coef_mux;
  logic signed [DELAY_BITS-1:0]   data_mux;
  logic signed [bqd_pkg::PROD_BITS-1:0] prod, prod_next;
  logic signed [ACC_BITS-1:0]     acc, acc_next, x_aligned;
  logic signed [ACC_BITS-1:0]     w_shift, y_shift;
  logic signed [DELAY_BITS-1:0]   w_sat;
  logic signed [SMP_BITS-1:0]     y_sat;

  assign idx_in = bqd_pkg::IDX_BITS'(chan_in);
  assign idx    = bqd_pkg::IDX_BITS'(chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqd_pkg::REG_B0: coef_b0 <= cfg_data;
        bqd_pkg::REG_B1: coef_b1 <= cfg_data;
        bqd_pkg::REG_B2: coef_b2 <= cfg_data;
        bqd_pkg::REG_A1: coef_a1 <= cfg_data;
        bqd_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bqd_pkg::CHANNELS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (cmd.state_wr) begin
      delay_one[idx] <= w;
      delay_two[idx] <= w1;
    end
  end

  always_comb begin
    case (cmd.coef_sel)
      bqd_pkg::CSEL_B0: coef_mux = coef_b0;
      bqd_pkg::CSEL_B1: coef_mux = coef_b1;
      bqd_pkg::CSEL_B2: coef_mux = coef_b2;
      bqd_pkg::CSEL_A1: coef_mux = coef_a1;
      bqd_pkg::CSEL_A2: coef_mux = coef_a2;
      default:          coef_mux = '0;
    endcase
    case (cmd.data_sel)
      bqd_pkg::DSEL_W1: data_mux = w1;
      bqd_pkg::DSEL_W2: data_mux = w2;
      bqd_pkg::DSEL_W:  data_mux = w;
      default:          data_mux = '0;
    endcase
  end

  assign prod_next = bqd_pkg::PROD_BITS'(coef_mux) * bqd_pkg::PROD_BITS'(data_mux);
  assign x_aligned = ACC_BITS'(x) <<< bqd_pkg::X_ALIGN;

  always_comb begin
    case (cmd.acc_op)
      bqd_pkg::ACC_LOAD_X: acc_next = x_aligned;
      bqd_pkg::ACC_SUB_P:  acc_next = acc - ACC_BITS'(prod);
      bqd_pkg::ACC_ADD_P:  acc_next = acc + ACC_BITS'(prod);
      bqd_pkg::ACC_LOAD_P: acc_next = ACC_BITS'(prod);
      default:             acc_next = acc;
    endcase
  end

  // round half up, then saturate
  assign w_shift = (acc + W_HALF) >>> bqd_pkg::COEF_FRAC;
  assign y_shift = (acc + Y_HALF) >>> bqd_pkg::Y_DROP;

  always_comb begin
    if (w_shift > W_MAX) begin
      w_sat = DELAY_BITS'(W_MAX);
    end else if (w_shift < W_MIN) begin
      w_sat = DELAY_BITS'(W_MIN);
    end else begin
      w_sat = DELAY_BITS'(w_shift);
    end
    if (y_shift > Y_MAX) begin
      y_sat = SMP_BITS'(Y_MAX);
    end else if (y_shift < Y_MIN) begin
      y_sat = SMP_BITS'(Y_MIN);
    end else begin
      y_sat = SMP_BITS'(y_shift);
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    acc  <= acc_next;
    if (cmd.capture) begin
      chan <= chan_in;
      x    <= sample_in;
      w1   <= delay_one[idx_in];
      w2   <= delay_two[idx_in];
    end
    if (cmd.w_load) begin
      w <= w_sat;
    end
    if (cmd.out_load) begin
      chan_out   <= chan;
      sample_out <= y_sat;
    end
  end

endmodule

/* hdl/biquad_df2_filter.sv */
// Top level of the multi-channel biquad direct form II filter.
//
// Input stream: s_tdata carries a signed Q1.23 sample, s_tuser the channel.
// Output stream: m_tdata carries the filtered Q1.23 sample, m_tuser its channel.
// Coefficients b0, b1, b2, a1, a2 (Q2.16) are written through cfg_we/cfg_index/cfg_data
// while the filter is idle; index 0..4 in that order, other indexes are ignored.
//
// Each sample runs through one shared 18x32 multiplier and an accumulator:
// five products in a fixed schedule, so one sample occupies the block for
// its accept step and seven datapath steps. No new input is taken while
// a sample is in progress; the next input is taken in the cycle after the
// result is loaded into the output register, which then raises m_tvalid.
// The output register holds a finished result while the next sample is
// already being processed; if the receiver stalls, the block waits at its
// last step until the output register is free.
// Reset (rst, synchronous) clears the coefficients, both delay values of
// every channel and the output valid flag.
module biquad_df2_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] sample_in
  input  logic [0:0]  s_tuser,   // [0] chan_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] sample_out
  output logic [0:0]  m_tuser,   // [0] chan_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  bqd_pkg::cmd_t cmd;
  logic signed [bqd_pkg::SAMPLE_BITS-1:0] sample_out;

  bqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bqd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chan_in    (s_tuser),
    .sample_in  ($signed(s_tdata)),
    .chan_out   (m_tuser),
    .sample_out (sample_out)
  );

  assign m_tdata = sample_out;

endmodule

/* hdl/bqd_checker.sv */
// Port-level checks for the biquad filter, bound to the top level.
module bqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken while a sample is in progress");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a sample in progress");

endmodule

bind biquad_df2_filter bqd_checker u_bqd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/tb_biquad_df2_filter.sv */
// Self-checking testbench for biquad_df2_filter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_biquad_df2_filter;

  localparam int CHANNELS     = bqd_pkg::CHANNELS;
  localparam int SAMPLE_BITS  = bqd_pkg::SAMPLE_BITS;
  localparam int COEF_BITS    = bqd_pkg::COEF_BITS;
  localparam int DELAY_BITS   = bqd_pkg::DELAY_BITS;
  localparam int CFG_IDX_BITS = bqd_pkg::CFG_IDX_BITS;
  localparam int COEF_FRAC    = bqd_pkg::COEF_FRAC;
  localparam int X_ALIGN      = bqd_pkg::X_ALIGN;
  localparam int Y_DROP       = bqd_pkg::Y_DROP;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] S_MIN = 24'h800000;
  localparam logic [COEF_BITS-1:0]   C_MAX = 18'h1FFFF;
  localparam logic [COEF_BITS-1:0]   C_MIN = 18'h20000;
  localparam logic [COEF_BITS-1:0]   C_ONE = 18'h10000;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = bqd_pkg::REG_A2 + 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP   = {CFG_IDX_BITS{1'b1}};
  localparam int DIR_ROWS    = 35;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 121;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {SET_MAX, SET_MIN, SET_STABLE, SET_RANDOM} coef_set_t;

  typedef struct packed {
    logic                   ch;
    logic [SAMPLE_BITS-1:0] smp;
  } filt_out_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [COEF_BITS-1:0]    val;
    logic                    ch;
    logic [SAMPLE_BITS-1:0]  smp;
    logic                    typed;
    logic [SAMPLE_BITS-1:0]  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [23:0] sample_in
  logic [0:0]  s_tuser = '0;   // [0] chan_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [23:0] sample_out
  logic [0:0]  m_tuser;        // [0] chan_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  logic signed [COEF_BITS-1:0]  k_b0, k_b1, k_b2, k_a1, k_a2;
  logic signed [DELAY_BITS-1:0] w1_mem [CHANNELS];
  logic signed [DELAY_BITS-1:0] w2_mem [CHANNELS];

  filt_out_t filt_q[$];
  int  errs = 0;
  int  n_in = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  held = 1'b0;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b1, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b1, 24'd0},
    '{1'b1, bqd_pkg::REG_B0, C_ONE, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b1, S_MAX},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b1, S_MIN},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{1'b1, bqd_pkg::REG_B0, C_MAX, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b1, S_MAX},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b1, S_MIN},
    '{1'b1, bqd_pkg::REG_B0, C_MIN, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b1, S_MIN},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b1, S_MAX},
    // a1 = -2.0 makes w double each step until the delay saturates
    '{1'b1, bqd_pkg::REG_B0, 18'd1, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, bqd_pkg::REG_B1, 18'd0, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, bqd_pkg::REG_B2, 18'd0, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, bqd_pkg::REG_A1, C_MIN, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, bqd_pkg::REG_A2, 18'd0, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, REG_SPARE, C_MAX, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b1, REG_TOP, C_MIN, 1'b0, 24'd0, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b0, S_MAX, 1'b0, 24'd0},
    '{1'b0, bqd_pkg::REG_B0, 18'd0, 1'b1, S_MIN, 1'b0, 24'd0}
  };

  biquad_df2_filter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    k_b0 = '0; k_b1 = '0; k_b2 = '0; k_a1 = '0; k_a2 = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      w1_mem[c] = '0;
      w2_mem[c] = '0;
    end
  end

  function automatic longint clamp(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // round half up, then floor
  function automatic longint round_drop(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] filter_predict(input logic ch,
                                                           input logic [SAMPLE_BITS-1:0] smp);
    longint x, d1, d2, acc, w, y;
    int ix;
    ix = (int'(ch) >= CHANNELS) ? CHANNELS - 1 : int'(ch);
    x  = longint'($signed(smp));
    d1 = w1_mem[ix];
    d2 = w2_mem[ix];
    acc = x * (longint'(1) << X_ALIGN) - longint'(k_a1) * d1 - longint'(k_a2) * d2;
    w = clamp(round_drop(acc, COEF_FRAC), DELAY_BITS);
    acc = longint'(k_b0) * w + longint'(k_b1) * d1 + longint'(k_b2) * d2;
    y = clamp(round_drop(acc, Y_DROP), SAMPLE_BITS);
    w2_mem[ix] = w1_mem[ix];
    w1_mem[ix] = w[DELAY_BITS-1:0];
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic void coef_store(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [COEF_BITS-1:0] val);
    case (idx)
      bqd_pkg::REG_B0: k_b0 = val;
      bqd_pkg::REG_B1: k_b1 = val;
      bqd_pkg::REG_B2: k_b2 = val;
      bqd_pkg::REG_A1: k_a1 = val;
      bqd_pkg::REG_A2: k_a2 = val;
      default: ;
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef(input int span);
    int r;
    r = int'($urandom_range(0, 2 * span)) - span;
    return r[COEF_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int r;
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        r = int'($urandom_range(0, 511)) - 256;
        return r[SAMPLE_BITS-1:0];
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    coef_store(idx, val);
  endtask

  task automatic program_coefs(input coef_set_t mode);
    logic [COEF_BITS-1:0] v [5];
    for (int k = 0; k < 5; k++) begin
      case (mode)
        SET_MAX:    v[k] = C_MAX;
        SET_MIN:    v[k] = C_MIN;
        SET_STABLE: v[k] = rand_coef((k == 4) ? 26000 : 32767);
        default:    v[k] = COEF_BITS'($urandom);
      endcase
    end
    write_coef(bqd_pkg::REG_B0, v[0]);
    write_coef(bqd_pkg::REG_B1, v[1]);
    write_coef(bqd_pkg::REG_B2, v[2]);
    write_coef(bqd_pkg::REG_A1, v[3]);
    write_coef(bqd_pkg::REG_A2, v[4]);
    write_coef(CFG_IDX_BITS'($urandom_range(REG_SPARE, REG_TOP)), COEF_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic ch, input logic [SAMPLE_BITS-1:0] smp,
                             input logic typed, input logic [SAMPLE_BITS-1:0] want);
    filt_out_t r;
    logic [SAMPLE_BITS-1:0] p;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tuser <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = filter_predict(ch, smp);
    r.ch = ch;
    r.smp = typed ? want : p;
    filt_q.push_back(r);
    n_in++;
  endtask

  initial begin
    coef_set_t modes [PHASES];
    bit prev_cfg;
    modes = '{SET_MAX, SET_MIN, SET_STABLE, SET_RANDOM, SET_STABLE, SET_RANDOM};
    prev_cfg = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg) begin
        if (!prev_cfg) drain();
        write_coef(dir_tab[i].idx, dir_tab[i].val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_sample(dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
        prev_cfg = 1'b0;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_coefs(modes[ph]);
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_sample(1'($urandom_range(0, 1)), rand_sample(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0)
      $display("biquad_df2_filter test passed");
    else
      $display("biquad_df2_filter test failed");
    $finish;
  end

  // receiver: random stalls plus one long hold so the input backs up
  initial begin
    @(posedge clk);
    forever begin
      if (!held && n_in >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : out_check
    filt_out_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (filt_q.size() == 0) begin
        $error("unexpected transfer: chan_out %0d sample_out %h", m_tuser[0], m_tdata);
        errs++;
      end else begin
        exp_r = filt_q.pop_front();
        if (m_tuser[0] !== exp_r.ch) begin
          $error("chan_out expected %0d actual %0d", exp_r.ch, m_tuser[0]);
          errs++;
        end
        if (m_tdata !== exp_r.smp) begin
          $error("sample_out expected %h actual %h", exp_r.smp, m_tdata);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("biquad_df2_filter test failed");
      $finish;
    end
  end

endmodule

/* files.f */
hdl/bqd_pkg.sv
hdl/bqd_ctrl.sv
hdl/bqd_datapath.sv
hdl/biquad_df2_filter.sv
hdl/bqd_checker.sv
tb/tb_biquad_df2_filter.sv
